/* rtl/core/assert_macros.svh */
// Assertion macros shared by the checker files.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cfq_pkg.sv */
// Package for the circular FIFO queue: field widths, codes, FSM states
// and the control struct passed from the controller to the top level.
package cfq_pkg;

  localparam int CMD_W         = 2;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int COUNT_W       = 5;
  localparam int CAP_W         = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam int DEPTH_DEF     = 16;
  localparam int ELEM_BITS_DEF = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ     = 2'd0,
    CMD_DEQ     = 2'd1,
    CMD_INSPECT = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  typedef struct packed {
    logic                 load;
    status_t              status;
    logic [COUNT_W-1:0]   count;
    logic                 empty;
    logic                 fwd_front;
    logic                 fwd_back;
  } res_ctl_t;

endpackage

/* rtl/core/cfq_ifs.sv */
// Handshake interfaces for the queue: command, result and capacity write.
// Depends on cfq_pkg for field widths.
interface cfq_in_if;
  import cfq_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [VALUE_W-1:0] push_value;
  modport source (output valid, cmd, push_value, input ready);
  modport sink   (input valid, cmd, push_value, output ready);
endinterface

interface cfq_out_if;
  import cfq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;
  logic [VALUE_W-1:0]  front_value;
  logic [VALUE_W-1:0]  back_value;
  modport source (output valid, status, count, front_value, back_value, input ready);
  modport sink   (input valid, status, count, front_value, back_value, output ready);
endinterface

interface cfq_cfg_if;
  import cfq_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;
  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

/* rtl/core/circular_fifo_queue_unit.sv */
// Circular FIFO queue top level: controller, two mirrored slot RAMs, result register.
// Command path: accept in idle, execute with RAM read, then the result register loads in the read state.
// A new command is accepted only after the last result is loaded; the controller waits in read while a result waits.
// The result register frees the controller while a result waits to be taken.
// Reset clears pointers and fill count and sets capacity to 16; slot RAM is not cleared.
// A capacity write empties the queue. Depends on cfq_pkg, cfq_ifs, cfq_ctrl, cfq_ram.
module circular_fifo_queue_unit #(
  parameter int DEPTH        = cfq_pkg::DEPTH_DEF,
  parameter int ELEMENT_BITS = cfq_pkg::ELEM_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cfq_in_if.sink    in_ch,
  cfq_out_if.source out_ch,
  cfq_cfg_if.sink   cfg_ch
);
  import cfq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  res_ctl_t                res;
  logic [ELEMENT_BITS-1:0] fwd_data;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [ELEMENT_BITS-1:0] ram_wdata;
  logic [AW-1:0]           ram_raddr_front;
  logic [AW-1:0]           ram_raddr_back;
  logic [ELEMENT_BITS-1:0] front_rd;
  logic [ELEMENT_BITS-1:0] back_rd;
  logic                    out_free;

  logic                    out_valid_r;
  logic [STATUS_W-1:0]     status_r;
  logic [COUNT_W-1:0]      count_r;
  logic [VALUE_W-1:0]      front_r, front_nxt;
  logic [VALUE_W-1:0]      back_r, back_nxt;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  cfq_ctrl #(
    .DEPTH        (DEPTH),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_cmd          (in_ch.cmd),
    .in_value        (in_ch.push_value),
    .cfg_valid       (cfg_ch.valid),
    .cfg_capacity    (cfg_ch.capacity),
    .out_free        (out_free),
    .res             (res),
    .fwd_data        (fwd_data),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr_front (ram_raddr_front),
    .ram_raddr_back  (ram_raddr_back)
  );

  cfq_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (DEPTH)
  ) u_ram_front (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr_front),
    .rdata (front_rd)
  );

  cfq_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (DEPTH)
  ) u_ram_back (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr_back),
    .rdata (back_rd)
  );

  always_comb begin
    if (res.empty) begin
      front_nxt = '0;
      back_nxt  = '0;
    end else begin
      front_nxt = VALUE_W'(res.fwd_front ? fwd_data : front_rd);
      back_nxt  = VALUE_W'(res.fwd_back ? fwd_data : back_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      status_r <= res.status;
      count_r  <= res.count;
      front_r  <= front_nxt;
      back_r   <= back_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.count       = count_r;
  assign out_ch.front_value = front_r;
  assign out_ch.back_value  = back_r;

endmodule

/* rtl/core/cfq_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module cfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/cfq_ctrl.sv */
// Queue controller: FSM, head/tail pointers, fill count, capacity register
// and RAM access with write-to-read forwarding. Depends on cfq_pkg.
module cfq_ctrl #(
  parameter int DEPTH        = cfq_pkg::DEPTH_DEF,
  parameter int ELEMENT_BITS = cfq_pkg::ELEM_BITS_DEF,
  localparam int AW    = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cfq_pkg::CMD_W-1:0]   in_cmd,
  input  logic [cfq_pkg::VALUE_W-1:0] in_value,
  input  logic                        cfg_valid,
  input  logic [cfq_pkg::CAP_W-1:0]   cfg_capacity,
  input  logic                        out_free,
  output cfq_pkg::res_ctl_t           res,
  output logic [ELEMENT_BITS-1:0]     fwd_data,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [ELEMENT_BITS-1:0]     ram_wdata,
  output logic [AW-1:0]               ram_raddr_front,
  output logic [AW-1:0]               ram_raddr_back
);
  import cfq_pkg::*;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [AW-1:0]        tail_r, tail_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [CAP_W-1:0]     cap_r, cap_nxt;
  status_t              status_r, status_nxt;
  logic                 empty_r, empty_nxt;
  logic                 fwd_front_r, fwd_front_nxt;
  logic                 fwd_back_r, fwd_back_nxt;
  logic [AW-1:0]        front_addr_r, front_addr_nxt;
  logic [AW-1:0]        back_addr_r, back_addr_nxt;
  logic [CMD_W-1:0]     cmd_r;
  logic [ELEMENT_BITS-1:0] val_r;

  logic [CNT_W-1:0]     cap_eff;
  logic [CNT_W-1:0]     head_inc, tail_inc;
  logic [AW-1:0]        head_adv, tail_adv;
  logic                 full;
  logic                 load;

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap_r) > 32'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  assign head_inc = CNT_W'(head_r) + CNT_W'(1);
  assign tail_inc = CNT_W'(tail_r) + CNT_W'(1);
  assign head_adv = (head_inc >= cap_eff) ? '0 : AW'(head_inc);
  assign tail_adv = (tail_inc >= cap_eff) ? '0 : AW'(tail_inc);
  assign full     = (fill_r >= cap_eff);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fill_nxt       = fill_r;
    cap_nxt        = cap_r;
    status_nxt     = status_r;
    empty_nxt      = empty_r;
    fwd_front_nxt  = 1'b0;
    fwd_back_nxt   = 1'b0;
    front_addr_nxt = front_addr_r;
    back_addr_nxt  = back_addr_r;
    ram_we         = 1'b0;
    in_ready       = 1'b0;
    load           = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = ST_OK;
        unique case (cmd_r)
          CMD_ENQ: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we   = 1'b1;
              fill_nxt = fill_r + CNT_W'(1);
              tail_nxt = tail_adv;
            end
          end
          CMD_DEQ: begin
            if (fill_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              fill_nxt = fill_r - CNT_W'(1);
              head_nxt = head_adv;
            end
          end
          default: begin
            status_nxt = ST_OK;
          end
        endcase
        front_addr_nxt = head_nxt;
        back_addr_nxt  = (tail_nxt == '0) ? AW'(cap_eff - CNT_W'(1))
                                          : tail_nxt - AW'(1);
        empty_nxt      = (fill_nxt == '0);
        // word written this cycle is not yet visible on the RAM read port
        fwd_front_nxt  = ram_we && (front_addr_nxt == tail_r);
        fwd_back_nxt   = ram_we && (back_addr_nxt == tail_r);
        state_nxt      = S_READ;
      end
      S_READ: begin
        load = out_free;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_valid) begin
      cap_nxt  = cfg_capacity;
      head_nxt = '0;
      tail_nxt = '0;
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      cap_r       <= CAP_RESET;
      fwd_front_r <= 1'b0;
      fwd_back_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      cap_r       <= cap_nxt;
      fwd_front_r <= fwd_front_nxt;
      fwd_back_r  <= fwd_back_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r     <= status_nxt;
    empty_r      <= empty_nxt;
    front_addr_r <= front_addr_nxt;
    back_addr_r  <= back_addr_nxt;
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd;
      val_r <= ELEMENT_BITS'(in_value);
    end
  end

  assign ram_waddr       = tail_r;
  assign ram_wdata       = val_r;
  assign ram_raddr_front = (state_r == S_EXEC) ? front_addr_nxt : front_addr_r;
  assign ram_raddr_back  = (state_r == S_EXEC) ? back_addr_nxt : back_addr_r;
  assign fwd_data        = val_r;

  always_comb begin
    res.load      = load;
    res.status    = status_r;
    res.count     = COUNT_W'(fill_r);
    res.empty     = empty_r;
    res.fwd_front = fwd_front_r;
    res.fwd_back  = fwd_back_r;
  end

endmodule

/* rtl/core/cfq_chk.sv */
// Port-level checker for the circular FIFO queue, bound to the top level.
// Depends on cfq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cfq_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [cfq_pkg::STATUS_W-1:0] out_status,
  input logic [cfq_pkg::COUNT_W-1:0]  out_count,
  input logic [cfq_pkg::VALUE_W-1:0]  out_front,
  input logic [cfq_pkg::VALUE_W-1:0]  out_back
);
  import cfq_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_count) && $stable(out_front) && $stable(out_back), "result word dropped or changed while stalled")
  `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "second command taken while one is in execution")
  `ASSERT_IMPL(a_empty_zero, clk, rst_n, out_valid && (out_count == '0), (out_front == '0) && (out_back == '0), "empty queue reports nonzero front or back")
  `ASSERT_IMPL(a_full_count, clk, rst_n, out_valid && (out_status == ST_FULL), out_count != '0, "full rejection with zero count")

endmodule

bind circular_fifo_queue_unit cfq_chk u_cfq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_count  (out_ch.count),
  .out_front  (out_ch.front_value),
  .out_back   (out_ch.back_value)
);
